### rtl/rcsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsm_pkg
// Shared field widths, operation and status codes and control types of the
// reference-counted cache slot manager.
// ----------------------------------------------------------------------------
package rcsm_pkg;

    localparam int FUNC_W   = 1;
    localparam int KEY_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_INC = 16'h0001;
    localparam logic [COUNT_W-1:0] COUNT_DEC = 16'hFFFF;

    localparam logic [FUNC_W-1:0] FUNC_LOCK    = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_REF   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // Write controls from the sequencer to the slot store.
    typedef struct packed {
        logic wr_en;   // write the count of the addressed slot
        logic tag_en;  // also retag the slot with the new key
    } wr_ctl_t;

endpackage

### rtl/rcsm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsm_req_if
// Request channel: one lock or release item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcsm_req_if;
    import rcsm_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    leaf_key;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, output func, output leaf_key, output slot_index,
                    input ready);
    modport sink   (input valid, input func, input leaf_key, input slot_index,
                    output ready);
endinterface

### rtl/rcsm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsm_rsp_if
// Response channel: one result item per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcsm_rsp_if;
    import rcsm_pkg::*;

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic                fill_needed;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output slot, output fill_needed, output status,
                    input ready);
    modport sink   (input valid, input slot, input fill_needed, input status,
                    output ready);
endinterface

### rtl/rcsm_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsm_slot_store
// Tag and count memories with one registered read port and one write port.
// A per-slot written flag stands in for the reset contents: a slot that was
// never written reads as an invalid tag with a zero count.
// ----------------------------------------------------------------------------
module rcsm_slot_store #(
    parameter int SLOTS    = 8,
    parameter int KEY_BITS = 16,
    parameter int IDX_W    = 3
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic                     rd_valid,
    output logic [KEY_BITS-1:0]      rd_key,
    output logic [rcsm_pkg::COUNT_W-1:0] rd_count,
    input  rcsm_pkg::wr_ctl_t        wr_ctl,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic [KEY_BITS-1:0]      wr_key,
    input  logic [rcsm_pkg::COUNT_W-1:0] wr_count
);
    import rcsm_pkg::*;

    logic [KEY_BITS-1:0] tag_mem [SLOTS];
    logic [COUNT_W-1:0]  cnt_mem [SLOTS];
    logic [SLOTS-1:0]    written_reg;

    logic                rd_written_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [COUNT_W-1:0]  rd_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_ctl.wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ctl.wr_en)
        begin
            cnt_mem[wr_addr] <= wr_count;
            if (wr_ctl.tag_en)
            begin
                tag_mem[wr_addr] <= wr_key;
            end
        end
        rd_written_reg <= written_reg[rd_addr];
        rd_key_reg     <= tag_mem[rd_addr];
        rd_count_reg   <= cnt_mem[rd_addr];
    end

    // Only a fill writes a slot for the first time, so a written slot always
    // holds a valid tag.
    assign rd_valid = rd_written_reg;
    assign rd_key   = rd_key_reg;
    assign rd_count = rd_written_reg ? rd_count_reg : '0;

endmodule

### rtl/refcounted_cache_slot_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_cache_slot_manager
// Tagged slot allocator with per-slot reference counts.
//
// Items arrive on the req channel and each gives exactly one result item on
// the rsp channel. A lock item (func 0) looks its key up among the slots,
// takes the first matching slot or else the first slot with a zero count
// (flagging a refill), and increments that slot's count. A release item
// (func 1) decrements the count of the named slot. Errors are reported in
// status and leave every slot untouched.
// One item is worked on at a time; req.ready is high only while idle. A lock
// scans the slots through the single read port of the slot store, one slot
// a cycle, then passes through a drain state and a decide state. A release
// reads the named slot and checks its count in the state after that read.
// Results sit in an output register; the next item is accepted while a
// result waits, but its own result is held back until rsp is free.
// Reset empties every slot at once: all tags invalid, all counts zero.
// ----------------------------------------------------------------------------
module refcounted_cache_slot_manager #(
    parameter int SLOTS    = 8,
    parameter int KEY_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    rcsm_req_if.sink      req,
    rcsm_rsp_if.source    rsp
);
    import rcsm_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_REL_RD,
        S_REL_CHK
    } state_t;

    state_t              state_reg,   state_next;
    logic [FUNC_W-1:0]   func_reg,    func_next;
    logic [KEY_BITS-1:0] key_reg,     key_next;
    logic [SLOT_W-1:0]   idx_reg,     idx_next;
    logic [IDX_W-1:0]    scan_reg,    scan_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                hit_reg,     hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic                free_reg,    free_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                out_valid_reg,  out_valid_next;
    logic [SLOT_W-1:0]   out_slot_reg,   out_slot_next;
    logic                out_fill_reg,   out_fill_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [IDX_W-1:0]    rd_addr;
    logic                rd_valid;
    logic [KEY_BITS-1:0] rd_key;
    logic [COUNT_W-1:0]  rd_count;
    wr_ctl_t             wr_ctl;
    logic [IDX_W-1:0]    wr_addr;
    logic [COUNT_W-1:0]  wr_count;

    logic [6:0]          idx_wide;
    logic [IDX_W-1:0]    rel_addr;
    logic                in_range;
    logic [IDX_W-1:0]    pick_idx;
    logic [6:0]          pick_wide;
    logic [COUNT_W-1:0]  pick_cnt;
    logic [COUNT_W-1:0]  cnt_src;
    logic [COUNT_W-1:0]  cnt_sum;
    logic                key_eq;
    logic                out_free;
    logic                load_out;

    rcsm_slot_store #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .rd_count (rd_count),
        .wr_ctl   (wr_ctl),
        .wr_addr  (wr_addr),
        .wr_key   (key_reg),
        .wr_count (wr_count)
    );

    assign idx_wide  = 7'(idx_reg);
    assign rel_addr  = idx_wide[IDX_W-1:0];
    assign in_range  = idx_wide < 7'(SLOTS);
    assign pick_idx  = hit_reg ? hit_idx_reg : free_idx_reg;
    assign pick_wide = 7'(pick_idx);
    // A fresh slot always starts from a zero count.
    assign pick_cnt  = hit_reg ? hit_cnt_reg : '0;

    // The one count adder, shared by lock and release.
    assign cnt_src   = (state_reg == S_REL_CHK) ? rd_count : pick_cnt;
    assign cnt_sum   = cnt_src + ((func_reg == FUNC_RELEASE) ? COUNT_DEC : COUNT_INC);
    assign wr_count  = cnt_sum;

    assign key_eq    = rd_valid && (rd_key == key_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rd_addr   = ((state_reg == S_REL_RD) || (state_reg == S_REL_CHK))
                       ? rel_addr : scan_reg;

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_fill_next   = out_fill_reg;
        out_status_next = out_status_reg;
        wr_ctl          = '0;
        wr_addr         = pick_idx;
        load_out        = 1'b0;

        // Compare the slot read in the previous cycle against the key, and note the first slot with a zero count.
        if (chk_vld_reg)
        begin
            if (key_eq && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = chk_idx_reg;
                hit_cnt_next = rd_count;
            end
            if ((rd_count == '0) && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = chk_idx_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next = req.func;
                    key_next  = KEY_BITS'(req.leaf_key);
                    idx_next  = req.slot_index;
                    scan_next = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    state_next = (req.func == FUNC_RELEASE) ? S_REL_RD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                chk_vld_next = 1'b1;
                chk_idx_next = scan_reg;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    out_fill_next = 1'b0;
                    if (!hit_reg && !free_reg)
                    begin
                        out_slot_next   = '0;
                        out_status_next = ST_NO_FREE;
                    end
                    else if (pick_cnt == COUNT_MAX)
                    begin
                        out_slot_next   = pick_wide[SLOT_W-1:0];
                        out_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_ctl.wr_en    = 1'b1;
                        wr_ctl.tag_en   = !hit_reg;
                        out_slot_next   = pick_wide[SLOT_W-1:0];
                        out_fill_next   = !hit_reg;
                        out_status_next = ST_OK;
                    end
                end
            end
            S_REL_RD:
            begin
                state_next = S_REL_CHK;
            end
            S_REL_CHK:
            begin
                wr_addr = rel_addr;
                if (out_free)
                begin
                    load_out      = 1'b1;
                    state_next    = S_IDLE;
                    out_slot_next = idx_reg;
                    out_fill_next = 1'b0;
                    if (!in_range || (rd_count == '0))
                    begin
                        out_status_next = ST_NO_REF;
                    end
                    else
                    begin
                        wr_ctl.wr_en    = 1'b1;
                        out_status_next = ST_OK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= FUNC_LOCK;
            key_reg        <= '0;
            idx_reg        <= '0;
            scan_reg       <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_cnt_reg    <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_fill_reg   <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            func_reg       <= func_next;
            key_reg        <= key_next;
            idx_reg        <= idx_next;
            scan_reg       <= scan_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            hit_cnt_reg    <= hit_cnt_next;
            free_reg       <= free_next;
            free_idx_reg   <= free_idx_next;
            out_valid_reg  <= out_valid_next;
            out_slot_reg   <= out_slot_next;
            out_fill_reg   <= out_fill_next;
            out_status_reg <= out_status_next;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.fill_needed = out_fill_reg;
    assign rsp.status      = out_status_reg;

    // Slot state changes only together with the result that reports it.
    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ctl.wr_en |=> rsp.valid)
        else $error("slot store written without a result item");

    // A retag belongs to a lock, never to a release.
    a_tag_on_lock: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ctl.tag_en |-> (wr_ctl.wr_en && (func_reg == FUNC_LOCK)))
        else $error("slot retagged outside a lock");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("item accepted while the previous one is in flight");

    // A refill is only ever requested with a successful lock.
    a_fill_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.fill_needed) |-> (rsp.status == ST_OK))
        else $error("refill flagged on an error result");

endmodule
